// ===== hw/rtl/fdmi_pkg.sv =====
`timescale 1ns / 1ps
// Package: payload types, constants, CORDIC angle table and sequencer states.
package fdmi_pkg;

    localparam int CordicIterationsDefault = 24;
    localparam int CordicIterationsMax     = 30;

    localparam logic signed [33:0] AngPi     = 34'sd843314857;
    localparam logic signed [33:0] AngHalfPi = 34'sd421657428;
    localparam logic signed [34:0] CordicGain = 35'sd652032874;

    typedef struct packed {
        logic signed [31:0] roll_rate_cmd;
        logic signed [31:0] pitch_rate_cmd;
        logic signed [31:0] heading_rate_cmd;
        logic signed [31:0] accel_forward;
        logic signed [31:0] accel_side;
        logic signed [31:0] accel_down;
        logic        [15:0] time_step;
    } fdmi_in_t;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] heading_angle;
        logic signed [31:0] body_rate_p;
        logic signed [31:0] body_rate_q;
        logic signed [31:0] body_rate_r;
        logic signed [31:0] vel_north;
        logic signed [31:0] vel_east;
        logic signed [31:0] vel_down;
    } fdmi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_CORD_LOAD,
        ST_CORD_RUN,
        ST_MUL,
        ST_DONE
    } fdmi_state_t;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] r;
        unique case (idx)
            5'd0: r = 32'sd210828714;
            5'd1: r = 32'sd124459457;
            5'd2: r = 32'sd65760959;
            5'd3: r = 32'sd33381290;
            5'd4: r = 32'sd16755422;
            5'd5: r = 32'sd8385879;
            5'd6: r = 32'sd4193963;
            5'd7: r = 32'sd2097109;
            5'd8: r = 32'sd1048571;
            5'd9: r = 32'sd524287;
            default:
            begin
                if (idx <= 5'd28)
                    r = 32'sd1 <<< (5'd28 - idx);
                else
                    r = 32'sd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/fdmi_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle, returns Q5.30 sine and cosine.
module fdmi_cordic
    import fdmi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterationsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [34:0] sin_val,
    output logic signed [34:0] cos_val
);

    logic signed [34:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [4:0]         it_reg, it_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [33:0] a_ext;
    logic signed [34:0] xs, ys;

    always_comb
    begin
        a_ext     = 34'(angle);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        if (start)
        begin
            x_next    = CordicGain;
            y_next    = '0;
            it_next   = '0;
            busy_next = 1'b1;
            neg_next  = 1'b0;
            z_next    = a_ext;
            // fold into the right half plane
            if (a_ext > AngHalfPi)
            begin
                z_next   = a_ext - AngPi;
                neg_next = 1'b1;
            end
            else if (a_ext < -AngHalfPi)
            begin
                z_next   = a_ext + AngPi;
                neg_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - 34'(atan_entry(it_reg));
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + 34'(atan_entry(it_reg));
            end
            it_next = it_reg + 5'd1;
            // flag done once the last rotation has landed in x/y
            if (it_reg == 5'(CORDIC_ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;
    assign cos_val = neg_reg ? -x_reg : x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== hw/rtl/fdmi_mac.sv =====
`timescale 1ns / 1ps
// Shared multiplier with round-half-up shift, registered result.
module fdmi_mac
    import fdmi_pkg::*;
(
    input  logic               clk,
    input  logic signed [34:0] a,
    input  logic signed [34:0] b,
    input  logic [4:0]         shift,
    output logic signed [63:0] prod
);

    logic signed [69:0] full;
    logic signed [69:0] rnd;

    always_comb
    begin
        full = 70'(a) * 70'(b);
        rnd  = (full + (70'sd1 <<< (shift - 5'd1))) >>> shift;
    end

    always_ff @(posedge clk)
    begin
        prod <= rnd[63:0];
    end

endmodule

// ===== hw/rtl/four_dof_motion_integrator_unit.sv =====
`timescale 1ns / 1ps
// Four degree-of-freedom motion integrator: Euler angles, body rates, NED speed.
//
// Input channel in_valid/in_stall carries one tick of rate and acceleration
// commands plus its time step; output channel out_valid/out_stall returns
// angles, body rates p/q/r and north/east/down speed. cfg_valid/cfg_ready
// writes the initial forward speed, which also loads body u at once.
// One shared multiplier and one shared CORDIC unit do all the arithmetic
// under a sequencer: six multiplies for the integration, three CORDIC runs,
// 28 multiplies for the direction cosines, rates and rotation, and a post
// state, ST_DONE. in_stall stays high from acceptance until the result is
// taken; out_valid holds with a stable payload while out_stall is high, and
// the next tick is accepted at the earliest in the cycle after the result
// transaction.
// Reset clears the sequencer, angles, speeds and stored commands; the
// forward speed returns to zero.
module four_dof_motion_integrator_unit
    import fdmi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterationsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fdmi_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fdmi_out_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data
);

    fdmi_state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  cix_reg, cix_next;

    logic signed [31:0] ang_reg [3];
    logic signed [31:0] prate_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] pacc_reg [3];
    logic [15:0]        pstep_reg;
    fdmi_in_t           cur_reg;
    fdmi_out_t          out_reg;
    logic               ov_reg, ov_next;
    // trig: 0 sphi 1 cphi 2 stht 3 ctht 4 spsi 5 cpsi; t: products
    logic signed [34:0] trig_reg [6];
    logic signed [34:0] t_reg [12];
    logic signed [63:0] acc_reg;

    logic signed [34:0] ma, mb;
    logic [4:0]         msh;
    logic signed [63:0] prod;
    logic               cstart, cdone;
    logic signed [31:0] cang;
    logic signed [34:0] csin, ccos;

    fdmi_mac u_mac (.clk(clk), .a(ma), .b(mb), .shift(msh), .prod(prod));

    fdmi_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cang),
        .done(cdone), .sin_val(csin), .cos_val(ccos)
    );

    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign cang      = ang_reg[cix_reg];

    // integration operand select: steps 0..5 issue, 1..6 retire
    function automatic logic signed [34:0] ab_diff(input logic signed [31:0] now,
                                                   input logic signed [31:0] pr);
        return 35'(now) * 35'sd3 - 35'(pr);
    endfunction

    logic signed [31:0] in_now [6];
    logic signed [31:0] in_pr [6];
    always_comb
    begin
        in_now[0] = cur_reg.roll_rate_cmd;
        in_now[1] = cur_reg.pitch_rate_cmd;
        in_now[2] = cur_reg.heading_rate_cmd;
        in_now[3] = cur_reg.accel_forward;
        in_now[4] = cur_reg.accel_side;
        in_now[5] = cur_reg.accel_down;
        in_pr[0]  = prate_reg[0];
        in_pr[1]  = prate_reg[1];
        in_pr[2]  = prate_reg[2];
        in_pr[3]  = pacc_reg[0];
        in_pr[4]  = pacc_reg[1];
        in_pr[5]  = pacc_reg[2];
    end

    // multiply program for ST_MUL: 28 products, index step_reg
    // 0 ctht*cpsi(l1) 1 ctht*spsi(l2) 2 sphi*stht(a) 3 cphi*stht(b)
    // 4 a*cpsi 5 cphi*spsi 6 a*spsi 7 cphi*cpsi 8 sphi*ctht(m3)
    // 9 b*cpsi 10 sphi*spsi 11 b*spsi 12 sphi*cpsi 13 cphi*ctht(n3)
    // t slots: 0 l1 1 l2 2 a 3 b 4 m1 5 m2 6 m3 7 n1 8 n2 9 n3
    // 14.. rates and velocities
    logic signed [34:0] l3;
    assign l3 = -trig_reg[2];

    always_comb
    begin
        ma  = '0;
        mb  = '0;
        msh = 5'd30;
        unique case (step_reg)
            6'd0:  begin ma = trig_reg[3]; mb = trig_reg[5]; end
            6'd1:  begin ma = trig_reg[3]; mb = trig_reg[4]; end
            6'd2:  begin ma = trig_reg[0]; mb = trig_reg[2]; end
            6'd3:  begin ma = trig_reg[1]; mb = trig_reg[2]; end
            6'd4:  begin ma = t_reg[2];    mb = trig_reg[5]; end
            6'd5:  begin ma = trig_reg[1]; mb = trig_reg[4]; end
            6'd6:  begin ma = t_reg[2];    mb = trig_reg[4]; end
            6'd7:  begin ma = trig_reg[1]; mb = trig_reg[5]; end
            6'd8:  begin ma = trig_reg[0]; mb = trig_reg[3]; end
            6'd9:  begin ma = t_reg[3];    mb = trig_reg[5]; end
            6'd10: begin ma = trig_reg[0]; mb = trig_reg[4]; end
            6'd11: begin ma = t_reg[3];    mb = trig_reg[4]; end
            6'd12: begin ma = trig_reg[0]; mb = trig_reg[5]; end
            6'd13: begin ma = trig_reg[1]; mb = trig_reg[3]; end
            6'd14: begin ma = l3;          mb = 35'(cur_reg.heading_rate_cmd); end
            6'd15: begin ma = trig_reg[1]; mb = 35'(cur_reg.pitch_rate_cmd); end
            6'd16: begin ma = t_reg[6];    mb = 35'(cur_reg.heading_rate_cmd); end
            6'd17: begin ma = -trig_reg[0]; mb = 35'(cur_reg.pitch_rate_cmd); end
            6'd18: begin ma = t_reg[9];    mb = 35'(cur_reg.heading_rate_cmd); end
            6'd19: begin ma = t_reg[0]; mb = 35'(vel_reg[0]); end
            6'd20: begin ma = t_reg[4]; mb = 35'(vel_reg[1]); end
            6'd21: begin ma = t_reg[7]; mb = 35'(vel_reg[2]); end
            6'd22: begin ma = t_reg[1]; mb = 35'(vel_reg[0]); end
            6'd23: begin ma = t_reg[5]; mb = 35'(vel_reg[1]); end
            6'd24: begin ma = t_reg[8]; mb = 35'(vel_reg[2]); end
            6'd25: begin ma = l3;       mb = 35'(vel_reg[0]); end
            6'd26: begin ma = t_reg[6]; mb = 35'(vel_reg[1]); end
            6'd27: begin ma = t_reg[9]; mb = 35'(vel_reg[2]); end
            default: begin ma = '0; mb = '0; end
        endcase
        if (state_reg == ST_INTEG && step_reg < 6'd6)
        begin
            ma  = ab_diff(in_now[step_reg[2:0]], in_pr[step_reg[2:0]]);
            mb  = 35'({1'b0, pstep_reg});
            msh = 5'd17;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cix_next   = cix_reg;
        ov_next    = ov_reg;
        cstart     = 1'b0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    state_next = ST_INTEG;
                    step_next  = '0;
                end
            end
            ST_INTEG:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd6)
                begin
                    state_next = ST_CORD_LOAD;
                    cix_next   = '0;
                end
            end
            ST_CORD_LOAD:
            begin
                cstart     = 1'b1;
                state_next = ST_CORD_RUN;
            end
            ST_CORD_RUN:
            begin
                if (cdone)
                begin
                    if (cix_reg == 2'd2)
                    begin
                        state_next = ST_MUL;
                        step_next  = '0;
                    end
                    else
                    begin
                        cix_next   = cix_reg + 2'd1;
                        state_next = ST_CORD_LOAD;
                    end
                end
            end
            ST_MUL:
            begin
                // result of step k lands while step k+1 issues; dependent steps come later in the program
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd28)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the product of a dependent step must be ready before use: steps 4,6 use
    // slot 2 written after step 2 retires (at step 3), steps 9,11 use slot 3
    // (retires at step 4), rates/velocity use slots written by step 14.
    logic signed [63:0] integ_sum;
    logic signed [31:0] wr_ang;
    always_comb
    begin
        integ_sum = '0;
        wr_ang    = '0;
        if (step_reg >= 6'd1 && step_reg <= 6'd6)
        begin
            if (step_reg <= 6'd3)
                integ_sum = 64'(ang_reg[step_reg[1:0] - 2'd1]) + prod;
            else
                integ_sum = 64'(vel_reg[2'(step_reg - 6'd4)]) + prod;
        end
        if (step_reg == 6'd2)
        begin
            if (integ_sum >= 64'(AngHalfPi))
                wr_ang = 32'(AngHalfPi - 34'sd1);
            else if (integ_sum <= -64'(AngHalfPi))
                wr_ang = 32'(-(AngHalfPi - 34'sd1));
            else
                wr_ang = integ_sum[31:0];
        end
        else
        begin
            if (integ_sum > 64'(AngPi))
                wr_ang = 32'(-AngPi);
            else if (integ_sum < -64'(AngPi))
                wr_ang = 32'(AngPi);
            else
                wr_ang = integ_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            cix_reg      <= '0;
            ov_reg       <= 1'b0;
            pstep_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i]   <= '0;
                prate_reg[i] <= '0;
                vel_reg[i]   <= '0;
                pacc_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cix_reg   <= cix_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                vel_reg[0]   <= cfg_data;
            end
            if (state_reg == ST_INTEG && step_reg >= 6'd1)
            begin
                if (step_reg <= 6'd3)
                    ang_reg[step_reg[1:0] - 2'd1] <= wr_ang;
                else
                    vel_reg[2'(step_reg - 6'd4)] <= sat32(integ_sum);
            end
            if (state_reg == ST_INTEG && step_reg == 6'd6)
            begin
                prate_reg[0] <= cur_reg.roll_rate_cmd;
                prate_reg[1] <= cur_reg.pitch_rate_cmd;
                prate_reg[2] <= cur_reg.heading_rate_cmd;
                pacc_reg[0]  <= cur_reg.accel_forward;
                pacc_reg[1]  <= cur_reg.accel_side;
                pacc_reg[2]  <= cur_reg.accel_down;
                pstep_reg    <= cur_reg.time_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !ov_reg)
            cur_reg <= in_data;
        if (state_reg == ST_CORD_RUN && cdone)
        begin
            trig_reg[{cix_reg, 1'b0}]       <= csin;
            trig_reg[{cix_reg, 1'b0} + 3'd1] <= ccos;
        end
        if (state_reg == ST_MUL && step_reg >= 6'd1)
        begin
            unique case (step_reg)
                6'd1:  t_reg[0] <= prod[34:0];
                6'd2:  t_reg[1] <= prod[34:0];
                6'd3:  t_reg[2] <= prod[34:0];
                6'd4:  t_reg[3] <= prod[34:0];
                6'd5:  acc_reg  <= prod;
                6'd6:  t_reg[4] <= 35'(acc_reg - prod);
                6'd7:  acc_reg  <= prod;
                6'd8:  t_reg[5] <= 35'(acc_reg + prod);
                6'd9:  t_reg[6] <= prod[34:0];
                6'd10: acc_reg  <= prod;
                6'd11: t_reg[7] <= 35'(acc_reg + prod);
                6'd12: acc_reg  <= prod;
                6'd13: t_reg[8] <= 35'(acc_reg - prod);
                6'd14: t_reg[9] <= prod[34:0];
                6'd15: out_reg.body_rate_p <= sat32(64'(cur_reg.roll_rate_cmd) + prod);
                6'd16: acc_reg <= prod;
                6'd17: out_reg.body_rate_q <= sat32(acc_reg + prod);
                6'd18: acc_reg <= prod;
                6'd19: out_reg.body_rate_r <= sat32(acc_reg + prod);
                6'd20: acc_reg <= prod;
                6'd21: acc_reg <= acc_reg + prod;
                6'd22: out_reg.vel_north <= sat32(acc_reg + prod);
                6'd23: acc_reg <= prod;
                6'd24: acc_reg <= acc_reg + prod;
                6'd25: out_reg.vel_east <= sat32(acc_reg + prod);
                6'd26: acc_reg <= prod;
                6'd27: acc_reg <= acc_reg + prod;
                6'd28: out_reg.vel_down <= sat32(acc_reg + prod);
                default: acc_reg <= acc_reg;
            endcase
        end
        if (state_reg == ST_DONE)
        begin
            out_reg.roll_angle    <= ang_reg[0];
            out_reg.pitch_angle   <= ang_reg[1];
            out_reg.heading_angle <= ang_reg[2];
        end
    end

endmodule

// ===== hw/rtl/fdmi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the motion integrator, bound to the top level.
module fdmi_checker
    import fdmi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input fdmi_out_t out_data,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under stall");

    // a transaction on the input is followed by busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after accept");

    // no new input while a result waits
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // config only while idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall && !out_valid)
        else $error("config ready while busy");

endmodule

bind four_dof_motion_integrator_unit fdmi_checker u_fdmi_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== dv/four_dof_motion_integrator_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts each tick's angles, rates and NED speed and compares results.
module four_dof_motion_integrator_unit_checker
    import fdmi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterationsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  fdmi_in_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  fdmi_out_t          out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic signed [31:0] cfg_data,
    output int                 errors,
    output int                 pending
);

    localparam longint PiQ28     = 64'sd843314857;
    localparam longint HalfPiQ28 = 64'sd421657428;
    localparam longint GainQ30   = 64'sd652032874;
    localparam longint HalfQ30   = 64'sd536870912;

    localparam longint ArctanLut [30] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    int          fwd_speed;
    int          roll_q;
    int          pitch_q;
    int          heading_q;
    int          last_rate [3];
    int          body_vel [3];
    int          last_accel [3];
    logic [15:0] last_dt;
    fdmi_out_t   tick_results [$];

    function automatic longint ab2_increment(int now, int prior, logic [15:0] dt);
        longint d;
        d = 3 * longint'(now) - longint'(prior);
        return (d * longint'(dt) + 64'sd65536) >>> 17;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + HalfQ30) >>> 30;
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int wrap_angle(longint a);
        if (a > PiQ28)
            a = -PiQ28;
        if (a < -PiQ28)
            a = PiQ28;
        return int'(a);
    endfunction

    function automatic int clamp_pitch(longint a);
        if (a >= HalfPiQ28)
            a = HalfPiQ28 - 1;
        if (a <= -HalfPiQ28)
            a = -(HalfPiQ28 - 1);
        return int'(a);
    endfunction

    function automatic void sin_cos(input int angle, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        z = angle;
        x = GainQ30;
        y = 0;
        flip = 1'b0;
        // fold into +/-pi/2 and negate the result afterwards
        if (z > HalfPiQ28)
        begin
            z -= PiQ28;
            flip = 1'b1;
        end
        else if (z < -HalfPiQ28)
        begin
            z += PiQ28;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= ArctanLut[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += ArctanLut[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic fdmi_out_t predict_tick(fdmi_in_t t);
        fdmi_out_t   r;
        logic [15:0] dt;
        int          rate [3];
        int          acc [3];
        longint      sphi, cphi, stht, ctht, spsi, cpsi;
        longint      l1, l2, l3, m1, m2, m3, n1, n2, n3;
        longint      u, v, w;
        dt = last_dt;
        rate[0] = t.roll_rate_cmd;
        rate[1] = t.pitch_rate_cmd;
        rate[2] = t.heading_rate_cmd;
        acc[0] = t.accel_forward;
        acc[1] = t.accel_side;
        acc[2] = t.accel_down;

        roll_q = wrap_angle(longint'(roll_q) + ab2_increment(rate[0], last_rate[0], dt));
        pitch_q = clamp_pitch(longint'(pitch_q) + ab2_increment(rate[1], last_rate[1], dt));
        heading_q = wrap_angle(longint'(heading_q)
                               + ab2_increment(rate[2], last_rate[2], dt));
        for (int i = 0; i < 3; i++)
            last_rate[i] = rate[i];

        sin_cos(roll_q, sphi, cphi);
        sin_cos(pitch_q, stht, ctht);
        sin_cos(heading_q, spsi, cpsi);

        l1 = q30_mul(ctht, cpsi);
        l2 = q30_mul(ctht, spsi);
        l3 = -stht;
        m1 = q30_mul(q30_mul(sphi, stht), cpsi) - q30_mul(cphi, spsi);
        m2 = q30_mul(q30_mul(sphi, stht), spsi) + q30_mul(cphi, cpsi);
        m3 = q30_mul(sphi, ctht);
        n1 = q30_mul(q30_mul(cphi, stht), cpsi) + q30_mul(sphi, spsi);
        n2 = q30_mul(q30_mul(cphi, stht), spsi) - q30_mul(sphi, cpsi);
        n3 = q30_mul(cphi, ctht);

        r.body_rate_p = clip32(longint'(rate[0]) + q30_mul(-stht, rate[2]));
        r.body_rate_q = clip32(q30_mul(cphi, rate[1]) + q30_mul(m3, rate[2]));
        r.body_rate_r = clip32(q30_mul(-sphi, rate[1]) + q30_mul(n3, rate[2]));

        for (int i = 0; i < 3; i++)
        begin
            body_vel[i] = clip32(longint'(body_vel[i])
                                 + ab2_increment(acc[i], last_accel[i], dt));
            last_accel[i] = acc[i];
        end
        u = body_vel[0];
        v = body_vel[1];
        w = body_vel[2];

        r.vel_north = clip32(q30_mul(l1, u) + q30_mul(m1, v) + q30_mul(n1, w));
        r.vel_east  = clip32(q30_mul(l2, u) + q30_mul(m2, v) + q30_mul(n2, w));
        r.vel_down  = clip32(q30_mul(l3, u) + q30_mul(m3, v) + q30_mul(n3, w));

        r.roll_angle    = roll_q;
        r.pitch_angle   = pitch_q;
        r.heading_angle = heading_q;
        last_dt = t.time_step;
        return r;
    endfunction

    task automatic check_field(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t mismatch %s: expected %0d (0x%08h) actual %0d (0x%08h)",
                         $realtime, fname, exp_v, exp_v, got_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fdmi_out_t e;
        if (!rst_n)
        begin
            fwd_speed = 0;
            roll_q = 0;
            pitch_q = 0;
            heading_q = 0;
            for (int i = 0; i < 3; i++)
            begin
                last_rate[i] = 0;
                body_vel[i] = 0;
                last_accel[i] = 0;
            end
            last_dt = '0;
            tick_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // retire the output transaction before predicting a new one
            if (out_valid && !out_stall)
            begin
                if (tick_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t unexpected result with no tick pending", $realtime);
                end
                else
                begin
                    e = tick_results.pop_front();
                    check_field("roll_angle", e.roll_angle, out_data.roll_angle);
                    check_field("pitch_angle", e.pitch_angle, out_data.pitch_angle);
                    check_field("heading_angle", e.heading_angle, out_data.heading_angle);
                    check_field("body_rate_p", e.body_rate_p, out_data.body_rate_p);
                    check_field("body_rate_q", e.body_rate_q, out_data.body_rate_q);
                    check_field("body_rate_r", e.body_rate_r, out_data.body_rate_r);
                    check_field("vel_north", e.vel_north, out_data.vel_north);
                    check_field("vel_east", e.vel_east, out_data.vel_east);
                    check_field("vel_down", e.vel_down, out_data.vel_down);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                fwd_speed = cfg_data;
                body_vel[0] = fwd_speed;
            end
            if (in_valid && !in_stall)
                tick_results.push_back(predict_tick(in_data));
            pending = tick_results.size();
        end
    end

endmodule

// ===== dv/four_dof_motion_integrator_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives ticks and speed settings into the integrator and reports the verdict.
module four_dof_motion_integrator_unit_test;
    import fdmi_pkg::*;

    localparam int IdleLimit     = 3000;
    localparam int TicksPerPhase = 240;
    localparam int NumPhases     = 5;
    localparam int LongHoldCyc   = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    fdmi_in_t           in_data;
    logic               out_valid;
    logic               out_stall;
    fdmi_out_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic signed [31:0] cfg_data;
    int                 errors;
    int                 pending;

    bit                 no_idle;
    int                 ticks_sent;
    int                 results_taken;
    int                 idle_cycles;

    four_dof_motion_integrator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    four_dof_motion_integrator_unit_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic fdmi_in_t make_tick(int r, int p, int h, int ax, int ay, int az,
                                           int dt);
        fdmi_in_t t;
        t.roll_rate_cmd    = r;
        t.pitch_rate_cmd   = p;
        t.heading_rate_cmd = h;
        t.accel_forward    = ax;
        t.accel_side       = ay;
        t.accel_down       = az;
        t.time_step        = dt[15:0];
        return t;
    endfunction

    // mostly moderate commands so the attitude walks through all quadrants,
    // with some full-range noise for the wrap, clamp and saturation paths
    function automatic fdmi_in_t random_tick();
        fdmi_in_t t;
        if ($urandom_range(0, 9) < 7)
        begin
            t.roll_rate_cmd    = $signed($urandom) >>> $urandom_range(2, 10);
            t.pitch_rate_cmd   = $signed($urandom) >>> $urandom_range(2, 10);
            t.heading_rate_cmd = $signed($urandom) >>> $urandom_range(2, 10);
            t.accel_forward    = $signed($urandom) >>> $urandom_range(6, 16);
            t.accel_side       = $signed($urandom) >>> $urandom_range(6, 16);
            t.accel_down       = $signed($urandom) >>> $urandom_range(6, 16);
            t.time_step        = 16'($urandom_range(0, 6000));
        end
        else
        begin
            t.roll_rate_cmd    = $urandom;
            t.pitch_rate_cmd   = $urandom;
            t.heading_rate_cmd = $urandom;
            t.accel_forward    = $urandom;
            t.accel_side       = $urandom;
            t.accel_down       = $urandom;
            t.time_step        = 16'($urandom_range(0, 65535));
        end
        return t;
    endfunction

    task automatic send_tick(input fdmi_in_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (in_stall);
        ticks_sent++;
    endtask

    task automatic write_speed(input logic signed [31:0] speed);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= speed;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic signed [31:0] speeds [NumPhases];
        fdmi_in_t           directed [$];
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        no_idle   = 1'b0;
        ticks_sent = 0;
        speeds = '{32'sh00050000, 32'sh7FFFFFFF, 32'sh80000000, $urandom, 32'sh0};

        // first tick integrates nothing; then hit both angle wraps, the pitch
        // clamp, speed saturation and zero steps
        directed.push_back(make_tick(0, 0, 0, 0, 0, 0, 65535));
        directed.push_back(make_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 65535));
        directed.push_back(make_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 65535));
        directed.push_back(make_tick(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                     32'sh80000000, 32'sh80000000, 32'sh80000000, 65535));
        directed.push_back(make_tick(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                     32'sh80000000, 32'sh80000000, 32'sh80000000, 0));
        directed.push_back(make_tick(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                                     32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1));
        directed.push_back(make_tick(-1, -1, -1, -1, -1, -1, 65535));
        directed.push_back(make_tick(268435456, 134217728, -268435456,
                                     65536, -65536, 32768, 16384));
        directed.push_back(make_tick(268435456, 134217728, -268435456,
                                     65536, -65536, 32768, 16384));
        directed.push_back(make_tick(843314857, 421657428, -843314857,
                                     0, 0, 0, 65535));
        directed.push_back(make_tick(843314857, 421657428, -843314857,
                                     0, 0, 0, 65535));
        directed.push_back(make_tick(-843314857, -421657428, 843314857,
                                     1 << 20, 1 << 20, -(1 << 20), 32768));
        directed.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NumPhases; ph++)
        begin
            write_speed(speeds[ph]);
            no_idle = (ph == 1);
            if (ph == 0)
                foreach (directed[i])
                    send_tick(directed[i]);
            for (int n = 0; n < TicksPerPhase; n++)
                send_tick(random_tick());
            in_valid <= 1'b0;
        end

        wait (pending == 0);
        repeat (200) @(posedge clk);
        $display("Ran %0d ticks across %0d forward-speed settings, including extremes,",
                 ticks_sent, NumPhases);
        $display("random idling on both sides and a %0d-cycle output hold.", LongHoldCyc);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall before each result, one long hold to back up the input
    initial
    begin
        int hold;
        out_stall <= 1'b1;
        results_taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (results_taken == 100)
                hold = LongHoldCyc;
            else
                hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall)
                 || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("Timeout: no transaction for %0d cycles", IdleLimit);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
